// ===== src/pvs_pkg.sv =====
// Shared types, constants and lookup functions for the regulator voltage selector codec.
// No dependencies; every other file of the block imports this package.
package pvs_pkg;

    // Request, result and configuration groups
    typedef struct packed {
        logic        operation;
        logic [22:0] min_uv;
        logic [22:0] max_uv;
        logic [7:0]  code_in;
    } t_req;

    typedef struct packed {
        logic [7:0]  code_out;
        logic [24:0] voltage_uv;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic        rail_is_linear;
        logic [1:0]  switcher_mode;
        logic [11:0] linear_min_mv;
        logic [11:0] linear_max_mv;
    } t_cfg;

    typedef enum logic [1:0] {
        CFG_RAIL_IS_LINEAR = 2'd0,
        CFG_SWITCHER_MODE  = 2'd1,
        CFG_LINEAR_MIN_MV  = 2'd2,
        CFG_LINEAR_MAX_MV  = 2'd3
    } t_cfg_idx;

    localparam logic       OP_ENCODE    = 1'b0;
    localparam logic       OP_DECODE    = 1'b1;
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_UNREP = 2'd1;
    localparam logic [1:0] STATUS_LIMIT = 2'd2;

    // How the back end of the pipe finishes a request
    typedef enum logic [1:0] {
        K_DIRECT  = 2'd0,   // result settled in the first stage
        K_SW_DIV  = 2'd1,   // switching rail encode, divide by step
        K_LIN_DIV = 2'd2,   // linear rail encode, divide by 100 mV
        K_DEC_MUL = 2'd3    // decode, offset plus code times step
    } t_kind;

    typedef enum logic [1:0] {
        STEP_SEL_PLAIN = 2'd0,
        STEP_SEL_EXT   = 2'd1,
        STEP_SEL_LIN   = 2'd2
    } t_step_sel;

    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned D_W         = 23;
    localparam int unsigned Q_W         = 10;
    localparam int unsigned STEP_W      = 17;
    localparam int unsigned RECIP_W     = 11;
    localparam int unsigned RPROD_W     = D_W + RECIP_W;
    localparam int unsigned MPROD_W     = Q_W + STEP_W;
    localparam int unsigned ACC_W       = 25;
    localparam int unsigned OFS_W       = 22;

    localparam logic [7:0]       FIXED_FIRST  = 8'd58;
    localparam logic [7:0]       FIXED_LAST   = 8'd62;
    localparam logic [Q_W:0]     SW_C_MAX     = 11'd56;
    localparam logic [Q_W:0]     LIN_Q_MIN    = 11'd10;
    localparam logic [Q_W:0]     LIN_Q_OFS    = 11'd9;
    localparam logic [OFS_W-1:0] LIN_DEC_BASE = 22'd900000;

    function automatic logic [STEP_W-1:0] step_of(input t_step_sel sel);
        logic [STEP_W-1:0] s;
        unique case (sel)
            STEP_SEL_PLAIN: s = 17'd12500;
            STEP_SEL_EXT:   s = 17'd38600;
            default:        s = 17'd100000;
        endcase
        return s;
    endfunction

    // floor(2^RECIP_SHIFT / step)
    function automatic logic [RECIP_W-1:0] recip_of(input t_step_sel sel);
        logic [RECIP_W-1:0] m;
        unique case (sel)
            STEP_SEL_PLAIN: m = 11'd1342;
            STEP_SEL_EXT:   m = 11'd434;
            default:        m = 11'd167;
        endcase
        return m;
    endfunction

    // For the switching steps, a remainder at or above a hundredth of the step rounds the code up
    function automatic logic [8:0] rnd_of(input t_step_sel sel);
        logic [8:0] r;
        unique case (sel)
            STEP_SEL_PLAIN: r = 9'd125;
            STEP_SEL_EXT:   r = 9'd386;
            default:        r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [OFS_W-1:0] base_of(input logic [1:0] mode);
        logic [OFS_W-1:0] b;
        unique case (mode)
            2'd0:    b = 22'd600000;
            2'd1:    b = 22'd700000;
            2'd2:    b = 22'd1852000;
            default: b = 22'd2161000;
        endcase
        return b;
    endfunction

    function automatic logic [D_W-1:0] ceil_of(input logic [1:0] mode);
        logic [D_W-1:0] c;
        unique case (mode)
            2'd0:    c = 23'd1300000;
            2'd1:    c = 23'd1420000;
            2'd2:    c = 23'd4013600;
            default: c = 23'd4321000;
        endcase
        return c;
    endfunction

    function automatic logic [OFS_W-1:0] fixed_level(input logic [1:0] mode,
                                                     input logic [2:0] idx);
        logic [OFS_W-1:0] lvl;
        if (!mode[1]) begin
            unique case (idx)
                3'd0:    lvl = 22'd1350000;
                3'd1:    lvl = 22'd1500000;
                3'd2:    lvl = 22'd1800000;
                3'd3:    lvl = 22'd1900000;
                3'd4:    lvl = 22'd2100000;
                default: lvl = '0;
            endcase
        end else begin
            unique case (idx)
                3'd0:    lvl = mode[0] ? 22'd4167000 : 22'd2084000;
                3'd1:    lvl = 22'd2315000;
                3'd2:    lvl = 22'd2778000;
                3'd3:    lvl = 22'd2932000;
                3'd4:    lvl = 22'd3241000;
                default: lvl = '0;
            endcase
        end
        return lvl;
    endfunction

    // Stage payloads
    typedef struct packed {
        t_kind            kind;
        t_step_sel        sel;
        logic [D_W-1:0]   d;
        logic [Q_W-1:0]   mul_a;
        logic [OFS_W-1:0] offset;
        t_rsp             dir;
        logic [OFS_W-1:0] lim_lo;
        logic [OFS_W-1:0] lim_hi;
        logic [D_W-1:0]   mx;
    } t_s1;

    typedef struct packed {
        t_kind            kind;
        t_step_sel        sel;
        logic [D_W-1:0]   d;
        logic [Q_W-1:0]   q_est;
        logic [ACC_W-1:0] prod;
        logic [OFS_W-1:0] offset;
        t_rsp             dir;
        logic             lim_fail;
    } t_s2;

    typedef struct packed {
        t_kind            kind;
        t_step_sel        sel;
        logic [Q_W-1:0]   q_est;
        logic [ACC_W-1:0] acc;
        t_rsp             dir;
        logic             lim_fail;
    } t_s3;

endpackage

// ===== src/pmic_voltage_selector_codec.sv =====
// Regulator voltage selector codec: top level with configuration registers and four-stage pipe.
// A request taken at a rising edge passes through the four register stages and shows its
// result, strobed by o_valid, for a single cycle. Throughput: one request every cycle;
// busy stays low and the receiver cannot hold results off.
// Reset (synchronous, active low) clears every stage valid bit and returns the configuration
// registers to their defaults; there is no clearing pass.
module pmic_voltage_selector_codec (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pvs_pkg::t_req i_req,
    output logic          o_valid,
    output pvs_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [11:0]   i_cfg_data
);
    import pvs_pkg::*;

    // Configuration registers. The user must change them only while the pipe is empty; the block
    // does not enforce it. Only stage one reads them; derived limits travel with each request.
    t_cfg r_cfg;
    t_cfg n_cfg;

    logic accept;
    logic s1_valid;
    t_s1  s1_data;
    logic s2_valid;
    t_s2  s2_data;
    logic s3_valid;
    t_s3  s3_data;

    // The pipe never stalls: hold busy low and take a request on every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RAIL_IS_LINEAR: n_cfg.rail_is_linear = i_cfg_data[0];
                CFG_SWITCHER_MODE:  n_cfg.switcher_mode  = i_cfg_data[1:0];
                CFG_LINEAR_MIN_MV:  n_cfg.linear_min_mv  = i_cfg_data;
                CFG_LINEAR_MAX_MV:  n_cfg.linear_max_mv  = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rail_is_linear <= 1'b0;
            r_cfg.switcher_mode  <= 2'd0;
            r_cfg.linear_min_mv  <= 12'd1100;
            r_cfg.linear_max_mv  <= 12'd3300;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Stage one: decide the request kind; settle zero, fixed-level and error answers;
    // estimate the quotient by reciprocal multiplication.
    pvs_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .o_valid (s1_valid),
        .o_s1    (s1_data)
    );

    // Stage two: multiply the estimate (or the decode code) by the step; test rail limits.
    pvs_multiply u_multiply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_s1    (s1_data),
        .o_valid (s2_valid),
        .o_s2    (s2_data)
    );

    // Stage three: remainder for encode, offset plus product for decode.
    pvs_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_s2    (s2_data),
        .o_valid (s3_valid),
        .o_s3    (s3_data)
    );

    // Stage four: advance the estimate by one where the remainder overshoots, round a switching
    // code up on a remainder of a hundredth step or more, range-check, drive the output register.
    pvs_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .i_s3    (s3_data),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== src/pvs_classify.sv =====
// First pipe stage: sort the request, settle the simple cases, estimate the quotient.
// Depends on pvs_pkg.
module pvs_classify (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pvs_pkg::t_req i_req,
    input  pvs_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output pvs_pkg::t_s1  o_s1
);
    import pvs_pkg::*;

    localparam logic [D_W-1:0] LVL62_MIN = 23'd1900000;
    localparam logic [D_W-1:0] LVL62_MAX = 23'd2100000;
    localparam logic [D_W-1:0] LVL61_MIN = 23'd1800000;
    localparam logic [D_W-1:0] LVL61_MAX = 23'd1900000;
    localparam logic [D_W-1:0] LVL60_MAX = 23'd1800000;
    localparam logic [D_W-1:0] LVL59_MIN = 23'd1350000;
    localparam logic [D_W-1:0] LVL59_MAX = 23'd1500000;
    localparam logic [D_W-1:0] LVL58_MIN = 23'd1300000;
    localparam logic [D_W-1:0] LVL58_MAX = 23'd1350000;
    localparam logic [7:0]     CODE_62   = 8'd62;
    localparam logic [7:0]     CODE_61   = 8'd61;
    localparam logic [7:0]     CODE_60   = 8'd60;
    localparam logic [7:0]     CODE_59   = 8'd59;
    localparam logic [7:0]     CODE_58   = 8'd58;

    logic                 r_valid;
    t_s1                  r_s1;
    t_s1                  n_s1;
    logic [1:0]           mode;
    logic [D_W-1:0]       mn;
    logic [D_W-1:0]       mx;
    logic [7:0]           code;
    logic [OFS_W-1:0]     base;
    logic [D_W-1:0]       lvl60_min;
    logic [7:0]           dec_k;
    logic [RPROD_W-1:0]   recip_prod;

    always_comb begin
        mode      = i_cfg.switcher_mode;
        mn        = i_req.min_uv;
        mx        = i_req.max_uv;
        code      = i_req.code_in;
        base      = base_of(mode);
        lvl60_min = mode[0] ? LVL59_MIN : LVL59_MAX;
        dec_k     = code;

        n_s1.kind   = K_DIRECT;
        n_s1.sel    = mode[1] ? STEP_SEL_EXT : STEP_SEL_PLAIN;
        n_s1.d      = mn;
        n_s1.offset = base;
        n_s1.dir    = '0;
        n_s1.lim_lo = OFS_W'(i_cfg.linear_min_mv) * 22'd1000;
        n_s1.lim_hi = (OFS_W'(i_cfg.linear_max_mv) + 22'd1) * 22'd1000;
        n_s1.mx     = mx;

        if (i_req.operation == OP_DECODE) begin
            if (i_cfg.rail_is_linear) begin
                n_s1.kind   = K_DEC_MUL;
                n_s1.sel    = STEP_SEL_LIN;
                n_s1.offset = LIN_DEC_BASE;
            end else if (code == '0) begin
                n_s1.kind = K_DIRECT;
            end else if (code < FIXED_FIRST) begin
                n_s1.kind = K_DEC_MUL;
                dec_k     = code - 8'd1;
            end else if (code <= FIXED_LAST) begin
                n_s1.dir.voltage_uv = ACC_W'(fixed_level(mode, 3'(code - FIXED_FIRST)));
            end else begin
                n_s1.dir.status = STATUS_UNREP;
            end
        end else if (i_cfg.rail_is_linear) begin
            n_s1.kind = K_LIN_DIV;
            n_s1.sel  = STEP_SEL_LIN;
        end else begin
            priority if (mn == '0) begin
                n_s1.kind = K_DIRECT;
            end else if (mn >= D_W'(base) && mx <= ceil_of(mode)) begin
                n_s1.kind = K_SW_DIV;
                n_s1.d    = mn - D_W'(base);
            end else if (mode[1]) begin
                n_s1.dir.status = STATUS_UNREP;
            end else if (mn > LVL62_MIN && mx >= LVL62_MAX) begin
                n_s1.dir.code_out = CODE_62;
            end else if (mn > LVL61_MIN && mx >= LVL61_MAX) begin
                n_s1.dir.code_out = CODE_61;
            end else if (mn > lvl60_min && mx >= LVL60_MAX) begin
                n_s1.dir.code_out = CODE_60;
            end else if (mn > LVL59_MIN && mx >= LVL59_MAX) begin
                n_s1.dir.code_out = CODE_59;
            end else if (mn > LVL58_MIN && mx >= LVL58_MAX) begin
                n_s1.dir.code_out = CODE_58;
            end else begin
                n_s1.dir.status = STATUS_UNREP;
            end
        end

        // Quotient estimate by reciprocal: never above the true value, at most one below
        recip_prod = RPROD_W'(n_s1.d) * RPROD_W'(recip_of(n_s1.sel));
        n_s1.mul_a = (n_s1.kind == K_DEC_MUL) ? Q_W'(dec_k)
                                              : recip_prod[RPROD_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

// ===== src/pvs_multiply.sv =====
// Second pipe stage: multiply quotient estimate or decode code by the step; check rail limits.
// Depends on pvs_pkg.
module pvs_multiply (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  pvs_pkg::t_s1 i_s1,
    output logic         o_valid,
    output pvs_pkg::t_s2 o_s2
);
    import pvs_pkg::*;

    logic               r_valid;
    t_s2                r_s2;
    t_s2                n_s2;
    logic [MPROD_W-1:0] prod;

    always_comb begin
        prod          = MPROD_W'(i_s1.mul_a) * MPROD_W'(step_of(i_s1.sel));
        n_s2.kind     = i_s1.kind;
        n_s2.sel      = i_s1.sel;
        n_s2.d        = i_s1.d;
        n_s2.q_est    = i_s1.mul_a;
        n_s2.prod     = prod[ACC_W-1:0];
        n_s2.offset   = i_s1.offset;
        n_s2.dir      = i_s1.dir;
        n_s2.lim_fail = (i_s1.d < D_W'(i_s1.lim_lo)) || (i_s1.mx >= D_W'(i_s1.lim_hi));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

// ===== src/pvs_combine.sv =====
// Third pipe stage: form the remainder for encode or the voltage for decode.
// Depends on pvs_pkg.
module pvs_combine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  pvs_pkg::t_s2 i_s2,
    output logic         o_valid,
    output pvs_pkg::t_s3 o_s3
);
    import pvs_pkg::*;

    logic r_valid;
    t_s3  r_s3;
    t_s3  n_s3;

    always_comb begin
        n_s3.kind     = i_s2.kind;
        n_s3.sel      = i_s2.sel;
        n_s3.q_est    = i_s2.q_est;
        n_s3.dir      = i_s2.dir;
        n_s3.lim_fail = i_s2.lim_fail;
        if (i_s2.kind == K_DEC_MUL) begin
            n_s3.acc = ACC_W'(i_s2.offset) + i_s2.prod;
        end else begin
            n_s3.acc = ACC_W'(i_s2.d) - i_s2.prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3 <= n_s3;
    end

    assign o_valid = r_valid;
    assign o_s3    = r_s3;

endmodule

// ===== src/pvs_finish.sv =====
// Last pipe stage: correct the quotient, round, range-check and register the result.
// Depends on pvs_pkg.
module pvs_finish (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pvs_pkg::t_s3  i_s3,
    output logic          o_valid,
    output pvs_pkg::t_rsp o_rsp
);
    import pvs_pkg::*;

    logic              r_valid;
    t_rsp              r_rsp;
    t_rsp              n_rsp;
    logic [ACC_W-1:0]  step;
    logic              over;
    logic [Q_W:0]      q;
    logic [ACC_W-1:0]  rem;
    logic              rnd;
    logic [Q_W:0]      c;

    always_comb begin
        step  = ACC_W'(step_of(i_s3.sel));
        over  = i_s3.acc >= step;
        q     = over ? (Q_W+1)'(i_s3.q_est) + 11'd1 : (Q_W+1)'(i_s3.q_est);
        rem   = over ? i_s3.acc - step : i_s3.acc;
        rnd   = rem >= ACC_W'(rnd_of(i_s3.sel));
        c     = q + (Q_W+1)'(rnd);
        n_rsp = '0;
        unique case (i_s3.kind)
            K_DIRECT: begin
                n_rsp = i_s3.dir;
            end
            K_SW_DIV: begin
                if (c > SW_C_MAX) begin
                    n_rsp.status = STATUS_UNREP;
                end else begin
                    n_rsp.code_out = 8'(c + 11'd1);
                end
            end
            K_LIN_DIV: begin
                if (i_s3.lim_fail) begin
                    n_rsp.status = STATUS_LIMIT;
                end else if (q < LIN_Q_MIN) begin
                    n_rsp.status = STATUS_UNREP;
                end else begin
                    n_rsp.code_out = 8'(q - LIN_Q_OFS);
                end
            end
            K_DEC_MUL: begin
                n_rsp.voltage_uv = i_s3.acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== src/pvs_checker.sv =====
// Port-level checks for the voltage selector codec, bound to the top level.
// Depends on pvs_pkg and pmic_voltage_selector_codec.
module pvs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input pvs_pkg::t_req i_req,
    input logic          o_valid,
    input pvs_pkg::t_rsp o_rsp
);
    import pvs_pkg::*;

    // Every accepted request gives its result
    a_req_to_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("accepted request produced no result");

    // No result without a matching accepted request
    a_rsp_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result without matching request");

    // Decode answers carry no code, encode answers carry no voltage
    a_decode_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(i_req.operation, 4) == OP_ENCODE || o_rsp.code_out == '0))
        else $error("decode result with non-zero code");

    a_encode_no_volt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(i_req.operation, 4) == OP_DECODE || o_rsp.voltage_uv == '0))
        else $error("encode result with non-zero voltage");

    // An error result is all zero apart from a known status code
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != STATUS_OK) |->
            (o_rsp.code_out == '0 && o_rsp.voltage_uv == '0 &&
             (o_rsp.status == STATUS_UNREP || o_rsp.status == STATUS_LIMIT)))
        else $error("error result with stray payload");

endmodule

bind pmic_voltage_selector_codec pvs_checker u_pvs_checker (.*);
